/* rtl/pbo_pkg.sv */
// Shared types, widths and helpers for the polyline bisector offset block.
package pbo_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int DIST_W      = 25;
  localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(262144);

  // Unit vectors are Q2.30.
  localparam int UNIT_SHIFT = 30;
  localparam int UNIT_W     = UNIT_SHIFT + 2;

  localparam int DIFF_W     = COORD_WIDTH + 1;
  localparam int MAG_W      = (DIFF_W > UNIT_W) ? DIFF_W : UNIT_W;
  localparam int NORM_STEPS = $clog2(MAG_W);
  localparam int NORM_W     = UNIT_SHIFT + 1;
  localparam int SQR_W      = 2 * NORM_W;
  localparam int SUM_W      = SQR_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int QUO_W      = NORM_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int NUM_W      = NORM_W + UNIT_SHIFT + 1;
  localparam int UNIT_LAT   = 1 + NORM_STEPS + 3 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  localparam int BIS_W      = UNIT_W + 1;
  localparam int PROD_W     = DIST_W + UNIT_W - 1;
  localparam int OFS_W      = PROD_W - UNIT_SHIFT + 1;
  localparam int CROSS_W    = 2 * UNIT_W + 1;
  localparam int SUM_OUT_W  = ((COORD_WIDTH > OFS_W) ? COORD_WIDTH : OFS_W) + 1;
  localparam int SAT_TOP_W  = SUM_OUT_W - COORD_WIDTH + 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] prev_x;
    logic signed [COORD_WIDTH-1:0] prev_y;
    logic signed [COORD_WIDTH-1:0] cur_x;
    logic signed [COORD_WIDTH-1:0] cur_y;
    logic signed [COORD_WIDTH-1:0] next_x;
    logic signed [COORD_WIDTH-1:0] next_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] inner_x;
    logic signed [COORD_WIDTH-1:0] inner_y;
    logic signed [COORD_WIDTH-1:0] outer_x;
    logic signed [COORD_WIDTH-1:0] outer_y;
    logic                          degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] cur_x;
    logic signed [COORD_WIDTH-1:0] cur_y;
    logic signed [DIFF_W-1:0]      d1_x;
    logic signed [DIFF_W-1:0]      d1_y;
    logic signed [DIFF_W-1:0]      d2_x;
    logic signed [DIFF_W-1:0]      d2_y;
    logic                          dir_zero;
  } dir_item_t;

  function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic [SUM_OUT_W-1:0] v);
    logic [SAT_TOP_W-1:0]   top;
    logic [COORD_WIDTH-1:0] r;
    top = v[SUM_OUT_W-1:COORD_WIDTH-1];
    if (top == '0 || top == '1) begin
      r = v[COORD_WIDTH-1:0];
    end else if (v[SUM_OUT_W-1]) begin
      r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* rtl/pbo_front.sv */
// Front end: forms the two direction vectors and flags zero-length ones.
module pbo_front import pbo_pkg::*; (
  input  in_item_t  item,
  output dir_item_t rec
);

  always_comb begin
    rec.cur_x = item.cur_x;
    rec.cur_y = item.cur_y;
    rec.d1_x  = DIFF_W'(item.cur_x) - DIFF_W'(item.prev_x);
    rec.d1_y  = DIFF_W'(item.cur_y) - DIFF_W'(item.prev_y);
    rec.d2_x  = DIFF_W'(item.next_x) - DIFF_W'(item.cur_x);
    rec.d2_y  = DIFF_W'(item.next_y) - DIFF_W'(item.cur_y);
    rec.dir_zero = ((item.cur_x == item.prev_x) && (item.cur_y == item.prev_y)) ||
                   ((item.next_x == item.cur_x) && (item.next_y == item.cur_y));
  end

endmodule

/* rtl/pbo_queue.sv */
// Small FIFO between the front end and the arithmetic back end.
module pbo_queue import pbo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  dir_item_t push_item,
  output logic      full,
  output logic      pop_v,
  output dir_item_t pop_item
);

  dir_item_t           mem_r [0:QDEPTH-1];
  logic [QPTR_W-1:0]   wp_r, wp_nxt;
  logic [QPTR_W-1:0]   rp_r, rp_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign pop_v    = (cnt_r != '0);
  assign pop_item = mem_r[rp_r];

  // The back end never stalls, so the head leaves whenever there is one.
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop_v ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

/* rtl/pbo_unit.sv */
// Pipelined scaling of a vector to Q2.30 unit length: normalize, square root, divide.
module pbo_unit import pbo_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_v,
  input  logic signed [MAG_W:0]    in_x,
  input  logic signed [MAG_W:0]    in_y,
  output logic                     out_v,
  output logic signed [UNIT_W-1:0] out_x,
  output logic signed [UNIT_W-1:0] out_y,
  output logic                     out_zero
);

  logic [MAG_W:0] ax, ay;

  // Normalizer stages.
  logic [NORM_STEPS:0]   nv_r, nsx_r, nsy_r, nz_r;
  logic [MAG_W-1:0]      nmx_r [0:NORM_STEPS];
  logic [MAG_W-1:0]      nmy_r [0:NORM_STEPS];
  logic [NORM_STEPS-1:0] nlz_r [0:NORM_STEPS];
  logic [MAG_W-1:0]      nmx_nxt [0:NORM_STEPS-1];
  logic [MAG_W-1:0]      nmy_nxt [0:NORM_STEPS-1];
  logic [NORM_STEPS-1:0] nlz_nxt [0:NORM_STEPS-1];

  // Select, square.
  logic              selv_r, selsx_r, selsy_r, selz_r;
  logic [NORM_W-1:0] selx_r, sely_r, selx_nxt, sely_nxt;
  logic              sqv_r, sqsx_r, sqsy_r, sqz_r;
  logic [NORM_W-1:0] sqmx_r, sqmy_r;
  logic [SQR_W-1:0]  sqx_r, sqy_r;

  // Square root stages.
  logic [SQRT_STEPS:0] sv_r, ssx_r, ssy_r, sz_r;
  logic [REM_W-1:0]    srem_r [0:SQRT_STEPS];
  logic [ROOT_W-1:0]   sroot_r [0:SQRT_STEPS];
  logic [SUM_W-1:0]    sval_r [0:SQRT_STEPS];
  logic [NORM_W-1:0]   smx_r [0:SQRT_STEPS];
  logic [NORM_W-1:0]   smy_r [0:SQRT_STEPS];
  logic [REM_W-1:0]    srem_nxt [0:SQRT_STEPS-1];
  logic [ROOT_W-1:0]   sroot_nxt [0:SQRT_STEPS-1];

  // Divider stages, two lanes sharing the divisor.
  logic [DIV_STEPS:0] dv_r, dsx_r, dsy_r, dz_r;
  logic [ROOT_W-1:0]  dlen_r [0:DIV_STEPS];
  logic [ROOT_W-1:0]  drx_r [0:DIV_STEPS];
  logic [ROOT_W-1:0]  dry_r [0:DIV_STEPS];
  logic [QUO_W-1:0]   dnx_r [0:DIV_STEPS];
  logic [QUO_W-1:0]   dny_r [0:DIV_STEPS];
  logic [QUO_W-1:0]   dqx_r [0:DIV_STEPS];
  logic [QUO_W-1:0]   dqy_r [0:DIV_STEPS];
  logic [ROOT_W-1:0]  drx_nxt [0:DIV_STEPS-1];
  logic [ROOT_W-1:0]  dry_nxt [0:DIV_STEPS-1];
  logic [QUO_W-1:0]   dqx_nxt [0:DIV_STEPS-1];
  logic [QUO_W-1:0]   dqy_nxt [0:DIV_STEPS-1];
  logic [NUM_W-1:0]   numx, numy;

  logic                     outv_r, outz_r;
  logic signed [UNIT_W-1:0] outx_r, outy_r;
  logic [UNIT_W-1:0]        qxe, qye;

  assign ax = in_x[MAG_W] ? -in_x : in_x;
  assign ay = in_y[MAG_W] ? -in_y : in_y;

  // Each stage tests the top bits of the OR of both magnitudes and shifts left
  // when they are clear, halving the shift amount from one stage to the next.
  always_comb begin
    logic [MAG_W-1:0] o;
    int               sh;
    for (int k = 0; k < NORM_STEPS; k++) begin
      sh = 1 << (NORM_STEPS - 1 - k);
      o  = nmx_r[k] | nmy_r[k];
      if ((o >> (MAG_W - sh)) == '0) begin
        nmx_nxt[k] = nmx_r[k] << sh;
        nmy_nxt[k] = nmy_r[k] << sh;
        nlz_nxt[k] = nlz_r[k] + NORM_STEPS'(sh);
      end else begin
        nmx_nxt[k] = nmx_r[k];
        nmy_nxt[k] = nmy_r[k];
        nlz_nxt[k] = nlz_r[k];
      end
    end
  end

  // A leading one at bit 30 or above keeps 31 bits (truncating below); lower
  // ones end up with the leading one at bit 29.
  always_comb begin
    if (nlz_r[NORM_STEPS] <= NORM_STEPS'(MAG_W - NORM_W)) begin
      selx_nxt = nmx_r[NORM_STEPS][MAG_W-1 -: NORM_W];
      sely_nxt = nmy_r[NORM_STEPS][MAG_W-1 -: NORM_W];
    end else begin
      selx_nxt = {1'b0, nmx_r[NORM_STEPS][MAG_W-1 -: NORM_W-1]};
      sely_nxt = {1'b0, nmy_r[NORM_STEPS][MAG_W-1 -: NORM_W-1]};
    end
  end

  // Digit-by-digit square root, two radicand bits per stage.
  always_comb begin
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] trial;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      t     = {srem_r[k], sval_r[k][SUM_W-1 -: 2]};
      trial = (REM_W+2)'({sroot_r[k], 2'b01});
      if (t >= trial) begin
        srem_nxt[k]  = REM_W'(t - trial);
        sroot_nxt[k] = {sroot_r[k][ROOT_W-2:0], 1'b1};
      end else begin
        srem_nxt[k]  = REM_W'(t);
        sroot_nxt[k] = {sroot_r[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Rounded quotient: numerator carries half the divisor.
  always_comb begin
    numx = (NUM_W'(smx_r[SQRT_STEPS]) << UNIT_SHIFT) + NUM_W'(sroot_r[SQRT_STEPS] >> 1);
    numy = (NUM_W'(smy_r[SQRT_STEPS]) << UNIT_SHIFT) + NUM_W'(sroot_r[SQRT_STEPS] >> 1);
  end

  // Restoring division, one quotient bit per stage.
  always_comb begin
    logic [ROOT_W:0] tx, ty, dd;
    for (int k = 0; k < DIV_STEPS; k++) begin
      dd = {1'b0, dlen_r[k]};
      tx = {drx_r[k], dnx_r[k][QUO_W-1]};
      ty = {dry_r[k], dny_r[k][QUO_W-1]};
      if (tx >= dd) begin
        drx_nxt[k] = ROOT_W'(tx - dd);
        dqx_nxt[k] = {dqx_r[k][QUO_W-2:0], 1'b1};
      end else begin
        drx_nxt[k] = ROOT_W'(tx);
        dqx_nxt[k] = {dqx_r[k][QUO_W-2:0], 1'b0};
      end
      if (ty >= dd) begin
        dry_nxt[k] = ROOT_W'(ty - dd);
        dqy_nxt[k] = {dqy_r[k][QUO_W-2:0], 1'b1};
      end else begin
        dry_nxt[k] = ROOT_W'(ty);
        dqy_nxt[k] = {dqy_r[k][QUO_W-2:0], 1'b0};
      end
    end
  end

  assign qxe = UNIT_W'(dqx_r[DIV_STEPS]);
  assign qye = UNIT_W'(dqy_r[DIV_STEPS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r   <= '0;
      selv_r <= 1'b0;
      sqv_r  <= 1'b0;
      sv_r   <= '0;
      dv_r   <= '0;
      outv_r <= 1'b0;
    end else begin
      nv_r   <= {nv_r[NORM_STEPS-1:0], in_v};
      selv_r <= nv_r[NORM_STEPS];
      sqv_r  <= selv_r;
      sv_r   <= {sv_r[SQRT_STEPS-1:0], sqv_r};
      dv_r   <= {dv_r[DIV_STEPS-1:0], sv_r[SQRT_STEPS]};
      outv_r <= dv_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    nsx_r    <= {nsx_r[NORM_STEPS-1:0], in_x[MAG_W]};
    nsy_r    <= {nsy_r[NORM_STEPS-1:0], in_y[MAG_W]};
    nz_r     <= {nz_r[NORM_STEPS-1:0], (in_x == '0) && (in_y == '0)};
    nmx_r[0] <= ax[MAG_W-1:0];
    nmy_r[0] <= ay[MAG_W-1:0];
    nlz_r[0] <= '0;
    for (int k = 0; k < NORM_STEPS; k++) begin
      nmx_r[k+1] <= nmx_nxt[k];
      nmy_r[k+1] <= nmy_nxt[k];
      nlz_r[k+1] <= nlz_nxt[k];
    end

    selx_r  <= selx_nxt;
    sely_r  <= sely_nxt;
    selsx_r <= nsx_r[NORM_STEPS];
    selsy_r <= nsy_r[NORM_STEPS];
    selz_r  <= nz_r[NORM_STEPS];

    sqx_r  <= SQR_W'(selx_r) * SQR_W'(selx_r);
    sqy_r  <= SQR_W'(sely_r) * SQR_W'(sely_r);
    sqmx_r <= selx_r;
    sqmy_r <= sely_r;
    sqsx_r <= selsx_r;
    sqsy_r <= selsy_r;
    sqz_r  <= selz_r;

    srem_r[0]  <= '0;
    sroot_r[0] <= '0;
    sval_r[0]  <= SUM_W'(sqx_r) + SUM_W'(sqy_r);
    smx_r[0]   <= sqmx_r;
    smy_r[0]   <= sqmy_r;
    ssx_r      <= {ssx_r[SQRT_STEPS-1:0], sqsx_r};
    ssy_r      <= {ssy_r[SQRT_STEPS-1:0], sqsy_r};
    sz_r       <= {sz_r[SQRT_STEPS-1:0], sqz_r};
    for (int k = 0; k < SQRT_STEPS; k++) begin
      srem_r[k+1]  <= srem_nxt[k];
      sroot_r[k+1] <= sroot_nxt[k];
      sval_r[k+1]  <= sval_r[k] << 2;
      smx_r[k+1]   <= smx_r[k];
      smy_r[k+1]   <= smy_r[k];
    end

    dlen_r[0] <= sroot_r[SQRT_STEPS];
    drx_r[0]  <= ROOT_W'(numx[NUM_W-1:QUO_W]);
    dry_r[0]  <= ROOT_W'(numy[NUM_W-1:QUO_W]);
    dnx_r[0]  <= numx[QUO_W-1:0];
    dny_r[0]  <= numy[QUO_W-1:0];
    dqx_r[0]  <= '0;
    dqy_r[0]  <= '0;
    dsx_r     <= {dsx_r[DIV_STEPS-1:0], ssx_r[SQRT_STEPS]};
    dsy_r     <= {dsy_r[DIV_STEPS-1:0], ssy_r[SQRT_STEPS]};
    dz_r      <= {dz_r[DIV_STEPS-1:0], sz_r[SQRT_STEPS]};
    for (int k = 0; k < DIV_STEPS; k++) begin
      dlen_r[k+1] <= dlen_r[k];
      drx_r[k+1]  <= drx_nxt[k];
      dry_r[k+1]  <= dry_nxt[k];
      dnx_r[k+1]  <= dnx_r[k] << 1;
      dny_r[k+1]  <= dny_r[k] << 1;
      dqx_r[k+1]  <= dqx_nxt[k];
      dqy_r[k+1]  <= dqy_nxt[k];
    end

    outx_r <= dsx_r[DIV_STEPS] ? -qxe : qxe;
    outy_r <= dsy_r[DIV_STEPS] ? -qye : qye;
    outz_r <= dz_r[DIV_STEPS];
  end

  assign out_v    = outv_r;
  assign out_x    = outx_r;
  assign out_y    = outy_r;
  assign out_zero = outz_r;

endmodule

/* rtl/pbo_back.sv */
// Back end: unit directions, bisector, offset points and the inner/outer choice.
module pbo_back import pbo_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_v,
  input  dir_item_t         in_rec,
  input  logic [DIST_W-1:0] offset_dist,
  output logic              out_valid,
  output out_item_t         out_item
);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] cur_x;
    logic signed [COORD_WIDTH-1:0] cur_y;
    logic                          deg;
  } side_a_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] cur_x;
    logic signed [COORD_WIDTH-1:0] cur_y;
    logic                          deg;
    logic signed [UNIT_W-1:0]      u2_x;
    logic signed [UNIT_W-1:0]      u2_y;
  } side_b_t;

  logic                     u1_v, u2_v, u3_v, u1_z, u2_z, u3_z;
  logic signed [UNIT_W-1:0] u1_x, u1_y, u2_x, u2_y, b_x, b_y;

  side_a_t da_r [0:UNIT_LAT-1];
  side_b_t db_r [0:UNIT_LAT-1];

  logic                    bv_r;
  logic signed [BIS_W-1:0] bsx_r, bsy_r;
  side_b_t                 bside_r;

  logic                      mv_r;
  logic [UNIT_W-1:0]         magx, magy;
  logic [PROD_W-1:0]         prodx_r, prody_r;
  logic                      oxneg_r, oyneg_r;
  logic signed [2*UNIT_W-1:0] cp1_r, cp2_r;
  side_a_t                   mside_r;

  logic                    sv_r, swap_r;
  logic [PROD_W-1:0]       rndx, rndy;
  logic [OFS_W-1:0]        px, py;
  logic signed [OFS_W-1:0] ofx_r, ofy_r;
  logic signed [CROSS_W-1:0] cross_sum;
  side_a_t                 sside_r;

  logic signed [SUM_OUT_W-1:0] cxe, cye, oxe, oye;
  logic [COORD_WIDTH-1:0]      plus_x, plus_y, minus_x, minus_y;

  logic      ov_r;
  out_item_t oitem_r, oitem_nxt;

  pbo_unit u_dir1 (
    .clk(clk), .rst_n(rst_n), .in_v(in_v),
    .in_x((MAG_W+1)'(in_rec.d1_x)), .in_y((MAG_W+1)'(in_rec.d1_y)),
    .out_v(u1_v), .out_x(u1_x), .out_y(u1_y), .out_zero(u1_z)
  );

  pbo_unit u_dir2 (
    .clk(clk), .rst_n(rst_n), .in_v(in_v),
    .in_x((MAG_W+1)'(in_rec.d2_x)), .in_y((MAG_W+1)'(in_rec.d2_y)),
    .out_v(u2_v), .out_x(u2_x), .out_y(u2_y), .out_zero(u2_z)
  );

  pbo_unit u_bis (
    .clk(clk), .rst_n(rst_n), .in_v(bv_r),
    .in_x((MAG_W+1)'(bsx_r)), .in_y((MAG_W+1)'(bsy_r)),
    .out_v(u3_v), .out_x(b_x), .out_y(b_y), .out_zero(u3_z)
  );

  // The normal is (-b.y, b.x), so the x offset takes the opposite sign of b.y.
  assign magx = b_x[UNIT_W-1] ? -b_x : b_x;
  assign magy = b_y[UNIT_W-1] ? -b_y : b_y;

  assign rndx  = prodx_r + (PROD_W'(1) << (UNIT_SHIFT - 1));
  assign rndy  = prody_r + (PROD_W'(1) << (UNIT_SHIFT - 1));
  assign px    = OFS_W'(rndx >> UNIT_SHIFT);
  assign py    = OFS_W'(rndy >> UNIT_SHIFT);
  // Outgoing direction crossed with the normal reduces to its dot with the bisector.
  assign cross_sum = CROSS_W'(cp1_r) + CROSS_W'(cp2_r);

  assign cxe = SUM_OUT_W'(sside_r.cur_x);
  assign cye = SUM_OUT_W'(sside_r.cur_y);
  assign oxe = SUM_OUT_W'(ofx_r);
  assign oye = SUM_OUT_W'(ofy_r);

  always_comb begin
    plus_x  = sat_coord(cxe + oxe);
    plus_y  = sat_coord(cye + oye);
    minus_x = sat_coord(cxe - oxe);
    minus_y = sat_coord(cye - oye);
    oitem_nxt.degenerate = sside_r.deg;
    if (sside_r.deg) begin
      oitem_nxt.inner_x = sside_r.cur_x;
      oitem_nxt.inner_y = sside_r.cur_y;
      oitem_nxt.outer_x = sside_r.cur_x;
      oitem_nxt.outer_y = sside_r.cur_y;
    end else if (swap_r) begin
      oitem_nxt.inner_x = plus_x;
      oitem_nxt.inner_y = plus_y;
      oitem_nxt.outer_x = minus_x;
      oitem_nxt.outer_y = minus_y;
    end else begin
      oitem_nxt.inner_x = minus_x;
      oitem_nxt.inner_y = minus_y;
      oitem_nxt.outer_x = plus_x;
      oitem_nxt.outer_y = plus_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= 1'b0;
      mv_r <= 1'b0;
      sv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      bv_r <= u1_v & u2_v;
      mv_r <= u3_v;
      sv_r <= mv_r;
      ov_r <= sv_r;
    end
  end

  always_ff @(posedge clk) begin
    da_r[0] <= '{cur_x: in_rec.cur_x, cur_y: in_rec.cur_y, deg: in_rec.dir_zero};
    for (int i = 1; i < UNIT_LAT; i++) begin
      da_r[i] <= da_r[i-1];
    end

    bsx_r         <= BIS_W'(u1_x) + BIS_W'(u2_x);
    bsy_r         <= BIS_W'(u1_y) + BIS_W'(u2_y);
    bside_r.cur_x <= da_r[UNIT_LAT-1].cur_x;
    bside_r.cur_y <= da_r[UNIT_LAT-1].cur_y;
    bside_r.deg   <= da_r[UNIT_LAT-1].deg | u1_z | u2_z;
    bside_r.u2_x  <= u2_x;
    bside_r.u2_y  <= u2_y;

    db_r[0] <= bside_r;
    for (int i = 1; i < UNIT_LAT; i++) begin
      db_r[i] <= db_r[i-1];
    end

    prodx_r       <= PROD_W'(offset_dist) * PROD_W'(magy[UNIT_W-2:0]);
    prody_r       <= PROD_W'(offset_dist) * PROD_W'(magx[UNIT_W-2:0]);
    oxneg_r       <= ~b_y[UNIT_W-1];
    oyneg_r       <= b_x[UNIT_W-1];
    cp1_r         <= db_r[UNIT_LAT-1].u2_x * b_x;
    cp2_r         <= db_r[UNIT_LAT-1].u2_y * b_y;
    mside_r.cur_x <= db_r[UNIT_LAT-1].cur_x;
    mside_r.cur_y <= db_r[UNIT_LAT-1].cur_y;
    mside_r.deg   <= db_r[UNIT_LAT-1].deg | u3_z;

    ofx_r   <= oxneg_r ? -px : px;
    ofy_r   <= oyneg_r ? -py : py;
    swap_r  <= cross_sum[CROSS_W-1];
    sside_r <= mside_r;

    oitem_r <= oitem_nxt;
  end

  assign out_valid = ov_r;
  assign out_item  = oitem_r;

endmodule

/* rtl/polyline_bisector_offset.sv */
// Top level of the polyline bisector offset block: front end, queue, back end, offset register.
// Path: an accepted item passes the queue, the two direction unit-vector pipelines, the bisector
// sum register, the bisector unit-vector pipeline and the product, offset and output registers;
// each unit-vector pipeline has a normalizer, a 32-stage square root and a 31-stage divider.
// Throughput: one item per cycle; the back end never stalls, so busy stays low.
// Reset clears the queue and all valid flags and loads the offset distance with 262144.
module polyline_bisector_offset import pbo_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_valid,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [DIST_W-1:0] cfg_wdata
);

  logic [DIST_W-1:0] dist_r;
  dir_item_t         front_rec, head_rec;
  logic              q_full, head_v, push;

  assign push = start & ~q_full;
  assign busy = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= DIST_RESET;
    end else if (cfg_we) begin
      dist_r <= cfg_wdata;
    end
  end

  pbo_front u_front (
    .item(in_item),
    .rec (front_rec)
  );

  pbo_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(front_rec),
    .full     (q_full),
    .pop_v    (head_v),
    .pop_item (head_rec)
  );

  pbo_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_v       (head_v),
    .in_rec     (head_rec),
    .offset_dist(dist_r),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule
